>>> hw/rtl/rfp_pkg.sv
package rfp_pkg;

    localparam int PERSIST_COUNT_DEF = 2;

    localparam int ADDR_W = 5;

    // Grid Vd window for the override flag, 1/16 V
    localparam logic signed [15:0] VD_LOW  = 16'sd4000;
    localparam logic signed [15:0] VD_HIGH = 16'sd5920;

    localparam logic [1:0] MODE_CHARGING = 2'd1;
    localparam logic [1:0] MODE_ONGRID   = 2'd2;

    localparam int FPGA_OC_BIT = 2;

    // Fault flag bit positions
    localparam int FLAG_OC_U  = 0;
    localparam int FLAG_OC_V  = 1;
    localparam int FLAG_OC_W  = 2;
    localparam int FLAG_BUS   = 3;
    localparam int FLAG_IMB   = 4;
    localparam int FLAG_FREQ  = 5;
    localparam int FLAG_FPGA  = 6;

    // Capture slots
    localparam int MARK_U    = 0;
    localparam int MARK_V    = 1;
    localparam int MARK_W    = 2;
    localparam int MARK_BUS  = 3;
    localparam int MARK_IMB  = 4;
    localparam int MARK_FREQ = 5;
    localparam int NUM_MARKS = 6;

    typedef enum logic [2:0] {
        REG_OC_LIMIT     = 3'd0,
        REG_SUM_HI_GRID  = 3'd1,
        REG_SUM_LO_GRID  = 3'd2,
        REG_SUM_HI_CHG   = 3'd3,
        REG_SUM_LO_CHG   = 3'd4,
        REG_DELTA_LIMIT  = 3'd5,
        REG_FREQ_HIGH    = 3'd6,
        REG_FREQ_LOW     = 3'd7
    } t_reg_idx;

    localparam logic [14:0] RST_OC_LIMIT    = 15'd6400;
    localparam logic [14:0] RST_SUM_HI_GRID = 15'd12000;
    localparam logic [14:0] RST_SUM_LO_GRID = 15'd10400;
    localparam logic [14:0] RST_SUM_HI_CHG  = 15'd11680;
    localparam logic [14:0] RST_SUM_LO_CHG  = 15'd8320;
    localparam logic [14:0] RST_DELTA_LIMIT = 15'd960;
    localparam logic [15:0] RST_FREQ_HIGH   = 16'd13312;
    localparam logic [15:0] RST_FREQ_LOW    = 16'd12288;

    typedef struct packed {
        logic [14:0] oc_limit;
        logic [14:0] sum_hi_grid;
        logic [14:0] sum_lo_grid;
        logic [14:0] sum_hi_chg;
        logic [14:0] sum_lo_chg;
        logic [14:0] delta_limit;
        logic [15:0] freq_high;
        logic [15:0] freq_low;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] current_u;
        logic signed [15:0] current_v;
        logic signed [15:0] current_w;
        logic signed [15:0] bus_voltage;
        logic signed [15:0] bus_imbalance;
        logic        [15:0] grid_frequency;
        logic signed [15:0] grid_vd;
        logic        [1:0]  run_mode;
        logic        [7:0]  ext_fault;
        logic               clear_faults;
    } t_item;

    typedef struct packed {
        logic        [6:0]  fault_flags;
        logic signed [15:0] bus_voltage_used;
        logic signed [15:0] bus_imbalance_used;
        logic               grid_override;
        logic signed [15:0] mark_u;
        logic signed [15:0] mark_v;
        logic signed [15:0] mark_w;
        logic signed [15:0] mark_bus;
        logic signed [15:0] mark_imbalance;
        logic        [15:0] mark_frequency;
    } t_result;

endpackage

>>> hw/rtl/rfp_cfg_regs.sv
module rfp_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output rfp_pkg::t_cfg              o_cfg
);
    import rfp_pkg::*;

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.oc_limit    <= RST_OC_LIMIT;
            r_cfg.sum_hi_grid <= RST_SUM_HI_GRID;
            r_cfg.sum_lo_grid <= RST_SUM_LO_GRID;
            r_cfg.sum_hi_chg  <= RST_SUM_HI_CHG;
            r_cfg.sum_lo_chg  <= RST_SUM_LO_CHG;
            r_cfg.delta_limit <= RST_DELTA_LIMIT;
            r_cfg.freq_high   <= RST_FREQ_HIGH;
            r_cfg.freq_low    <= RST_FREQ_LOW;
        end else if (wr_en) begin
            case (idx)
                REG_OC_LIMIT:    r_cfg.oc_limit    <= pwdata[14:0];
                REG_SUM_HI_GRID: r_cfg.sum_hi_grid <= pwdata[14:0];
                REG_SUM_LO_GRID: r_cfg.sum_lo_grid <= pwdata[14:0];
                REG_SUM_HI_CHG:  r_cfg.sum_hi_chg  <= pwdata[14:0];
                REG_SUM_LO_CHG:  r_cfg.sum_lo_chg  <= pwdata[14:0];
                REG_DELTA_LIMIT: r_cfg.delta_limit <= pwdata[14:0];
                REG_FREQ_HIGH:   r_cfg.freq_high   <= pwdata[15:0];
                REG_FREQ_LOW:    r_cfg.freq_low    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_OC_LIMIT:    prdata = {17'd0, r_cfg.oc_limit};
            REG_SUM_HI_GRID: prdata = {17'd0, r_cfg.sum_hi_grid};
            REG_SUM_LO_GRID: prdata = {17'd0, r_cfg.sum_lo_grid};
            REG_SUM_HI_CHG:  prdata = {17'd0, r_cfg.sum_hi_chg};
            REG_SUM_LO_CHG:  prdata = {17'd0, r_cfg.sum_lo_chg};
            REG_DELTA_LIMIT: prdata = {17'd0, r_cfg.delta_limit};
            REG_FREQ_HIGH:   prdata = {16'd0, r_cfg.freq_high};
            REG_FREQ_LOW:    prdata = {16'd0, r_cfg.freq_low};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/rfp_core.sv
module rfp_core #(
    parameter int PERSIST_COUNT = rfp_pkg::PERSIST_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  rfp_pkg::t_item   i_item,
    input  rfp_pkg::t_cfg    i_cfg,
    output rfp_pkg::t_result o_result
);
    import rfp_pkg::*;

    localparam logic [3:0] PERSIST = 4'(PERSIST_COUNT);

    function automatic logic [1:0] bump(input logic [1:0] c, input logic fail);
        if (!fail) begin
            return 2'd0;
        end
        return (c == 2'd3) ? 2'd3 : c + 2'd1;
    endfunction

    function automatic logic over_mag(input logic signed [15:0] v,
                                      input logic [14:0] lim);
        logic signed [16:0] ve;
        logic signed [16:0] le;
        ve = {v[15], v};
        le = {2'b00, lim};
        return (ve > le) || (ve < -le);
    endfunction

    logic [1:0]         r_cnt_ph [3];
    logic [1:0]         r_cnt_bus, r_cnt_imb;
    logic signed [15:0] r_good_bus, r_good_imb;
    logic [6:0]         r_sticky;
    logic [15:0]        r_mark [NUM_MARKS];

    logic [1:0]         n_cnt_ph [3];
    logic [1:0]         n_cnt_bus, n_cnt_imb;
    logic signed [15:0] n_good_bus, n_good_imb;
    logic [6:0]         n_sticky;
    logic [15:0]        n_mark [NUM_MARKS];

    logic signed [15:0] cur [3];
    logic signed [15:0] bus1, imb1, bus2, imb2;
    logic signed [16:0] bus_e, hi_e, lo_e;
    logic [14:0]        hi, lo;
    logic               chk_on, sum_fail, imb_fail;

    assign cur[0] = i_item.current_u;
    assign cur[1] = i_item.current_v;
    assign cur[2] = i_item.current_w;

    assign chk_on = (i_item.run_mode == MODE_CHARGING) || (i_item.run_mode == MODE_ONGRID);
    assign hi     = (i_item.run_mode == MODE_ONGRID) ? i_cfg.sum_hi_grid : i_cfg.sum_hi_chg;
    assign lo     = (i_item.run_mode == MODE_ONGRID) ? i_cfg.sum_lo_grid : i_cfg.sum_lo_chg;
    assign bus_e  = {i_item.bus_voltage[15], i_item.bus_voltage};
    assign hi_e   = {2'b00, hi};
    assign lo_e   = {2'b00, lo};

    always_comb begin
        n_sticky = i_item.clear_faults ? 7'd0 : r_sticky;
        for (int k = 0; k < NUM_MARKS; k++) begin
            n_mark[k] = r_mark[k];
        end

        // Phase overcurrent with persistence
        for (int k = 0; k < 3; k++) begin
            n_cnt_ph[k] = bump(r_cnt_ph[k], over_mag(cur[k], i_cfg.oc_limit));
            if ({2'b00, n_cnt_ph[k]} > PERSIST) begin
                n_sticky[FLAG_OC_U + k] = 1'b1;
                n_mark[MARK_U + k]      = cur[k];
            end
        end

        // Bus sum first, then imbalance on what the sum check leaves
        n_cnt_bus  = r_cnt_bus;
        n_cnt_imb  = r_cnt_imb;
        n_good_bus = r_good_bus;
        n_good_imb = r_good_imb;
        bus1       = i_item.bus_voltage;
        imb1       = i_item.bus_imbalance;
        bus2       = i_item.bus_voltage;
        imb2       = i_item.bus_imbalance;
        sum_fail   = (bus_e > hi_e) || (bus_e < lo_e);
        imb_fail   = 1'b0;
        if (chk_on) begin
            n_cnt_bus = bump(r_cnt_bus, sum_fail);
            if (sum_fail) begin
                bus1 = r_good_bus;
                imb1 = r_good_imb;
            end else begin
                n_good_bus = i_item.bus_voltage;
            end
            imb_fail  = over_mag(imb1, i_cfg.delta_limit);
            n_cnt_imb = bump(r_cnt_imb, imb_fail);
            bus2      = bus1;
            imb2      = imb1;
            if (imb_fail) begin
                bus2 = n_good_bus;
                imb2 = r_good_imb;
            end else begin
                n_good_imb = imb1;
            end
        end

        if ({2'b00, n_cnt_bus} > PERSIST) begin
            n_sticky[FLAG_BUS] = 1'b1;
            n_mark[MARK_BUS]   = bus2;
        end
        if ({2'b00, n_cnt_imb} > PERSIST) begin
            n_sticky[FLAG_IMB] = 1'b1;
            n_mark[MARK_IMB]   = imb2;
        end
        if ((i_item.grid_frequency > i_cfg.freq_high) ||
            (i_item.grid_frequency < i_cfg.freq_low)) begin
            n_sticky[FLAG_FREQ] = 1'b1;
            n_mark[MARK_FREQ]   = i_item.grid_frequency;
        end
        if (i_item.ext_fault[FPGA_OC_BIT]) begin
            n_sticky[FLAG_FPGA] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_cnt_ph[k] <= 2'd0;
            end
            r_cnt_bus  <= 2'd0;
            r_cnt_imb  <= 2'd0;
            r_good_bus <= '0;
            r_good_imb <= '0;
            r_sticky   <= '0;
            for (int k = 0; k < NUM_MARKS; k++) begin
                r_mark[k] <= '0;
            end
        end else if (i_adv) begin
            r_cnt_ph   <= n_cnt_ph;
            r_cnt_bus  <= n_cnt_bus;
            r_cnt_imb  <= n_cnt_imb;
            r_good_bus <= n_good_bus;
            r_good_imb <= n_good_imb;
            r_sticky   <= n_sticky;
            r_mark     <= n_mark;
        end
    end

    assign o_result.fault_flags        = n_sticky;
    assign o_result.bus_voltage_used   = bus2;
    assign o_result.bus_imbalance_used = imb2;
    assign o_result.grid_override      = (i_item.grid_vd < VD_LOW) || (i_item.grid_vd > VD_HIGH);
    assign o_result.mark_u             = n_mark[MARK_U];
    assign o_result.mark_v             = n_mark[MARK_V];
    assign o_result.mark_w             = n_mark[MARK_W];
    assign o_result.mark_bus           = n_mark[MARK_BUS];
    assign o_result.mark_imbalance     = n_mark[MARK_IMB];
    assign o_result.mark_frequency     = n_mark[MARK_FREQ];

endmodule

>>> hw/rtl/rectifier_fault_protection.sv
// Rectifier fault protection: one control tick per input item.
// Input stream (s_axis): one item carries the phase currents, DC bus sum and
// imbalance, grid frequency and Vd, run mode, FPGA fault byte and the clear
// request. Output stream (m_axis): one result item per input item with the
// sticky fault flags, the bus values after last-good substitution, the grid
// override flag and the six captured values.
// Configuration: APB write/read of the eight limit registers at 4*index;
// pready is tied high. Write only while the block is idle.
// Path: an accepted item sits in the input register; its result is loaded
// into the output register once it is free, and is offered from then on.
// Throughput: one item per cycle unless m_axis_tready stalls, set by the single
// check pass from input to output register, which also updates the counters.
// Stall: when m_axis_tready is low the result holds; one more item is taken
// into the input register, then s_axis_tready drops until the result goes.
// Reset (synchronous, active low): both registers empty, counters, last-good
// values, sticky flags and captures zero, limits at their defaults.
module rectifier_fault_protection #(
    parameter int PERSIST_COUNT = rfp_pkg::PERSIST_COUNT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // current_u, current_v, current_w, bus_voltage, bus_imbalance,
    // grid_frequency, grid_vd, run_mode, ext_fault, clear_faults, zero pad
    input  logic [127:0]               s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // fault_flags, bus_voltage_used, bus_imbalance_used, grid_override,
    // mark_u, mark_v, mark_w, mark_bus, mark_imbalance, mark_frequency
    output logic [135:0]               m_axis_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import rfp_pkg::*;

    t_cfg    cfg;
    t_item   in_item;
    t_result res;

    logic    r_in_valid, r_out_valid;
    t_item   r_in;
    t_result r_out;
    logic    adv;

    rfp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Unpack the input item, lowest field first
    assign in_item.current_u      = s_axis_tdata[15:0];
    assign in_item.current_v      = s_axis_tdata[31:16];
    assign in_item.current_w      = s_axis_tdata[47:32];
    assign in_item.bus_voltage    = s_axis_tdata[63:48];
    assign in_item.bus_imbalance  = s_axis_tdata[79:64];
    assign in_item.grid_frequency = s_axis_tdata[95:80];
    assign in_item.grid_vd        = s_axis_tdata[111:96];
    assign in_item.run_mode       = s_axis_tdata[113:112];
    assign in_item.ext_fault      = s_axis_tdata[121:114];
    assign in_item.clear_faults   = s_axis_tdata[122];

    // Advance the held item into the output register when that slot frees
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= in_item;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    rfp_core #(
        .PERSIST_COUNT (PERSIST_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (res)
    );

    assign m_axis_tvalid         = r_out_valid;
    assign m_axis_tdata[6:0]     = r_out.fault_flags;
    assign m_axis_tdata[22:7]    = r_out.bus_voltage_used;
    assign m_axis_tdata[38:23]   = r_out.bus_imbalance_used;
    assign m_axis_tdata[39]      = r_out.grid_override;
    assign m_axis_tdata[55:40]   = r_out.mark_u;
    assign m_axis_tdata[71:56]   = r_out.mark_v;
    assign m_axis_tdata[87:72]   = r_out.mark_w;
    assign m_axis_tdata[103:88]  = r_out.mark_bus;
    assign m_axis_tdata[119:104] = r_out.mark_imbalance;
    assign m_axis_tdata[135:120] = r_out.mark_frequency;

endmodule
